[rtl/hfd_pkg.sv]
`default_nettype none

package hfd_pkg;

  localparam int TABLE_BITS_DEF  = 12;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int OP_W     = 1;
  localparam int INDEX_W  = 12;
  localparam int TSYM_W   = 8;
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int VBITS_W  = 4;
  localparam int SYM_W    = 8;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_MARK
  } hfd_state_t;

endpackage

`default_nettype wire

[rtl/hfd_table.sv]
`default_nettype none

module hfd_table #(
  parameter int TABLE_BITS = 12,
  parameter int ENTRY_W    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [TABLE_BITS-1:0] wr_addr,
  input  wire logic [ENTRY_W-1:0]    wr_data,
  input  wire logic                  rd_en,
  input  wire logic [TABLE_BITS-1:0] rd_addr,
  output logic      [ENTRY_W-1:0]    rd_data
);

  logic [ENTRY_W-1:0] mem [2**TABLE_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/huffman_table_decoder.sv]
// Single-table Huffman decoder. Load items (op = 0) write one entry of a
// 2^TABLE_BITS entry table of symbol and code length; the user must write
// the whole table before data arrives, which the block does not enforce.
// Data items (op = 1) append valid_bits bits (at most 8) of data_byte, least
// significant bit first, to a bit buffer, and the decoder looks up the next
// TABLE_BITS bits, emits one result per code and drops the code length,
// until fewer than TABLE_BITS bits remain (or none, on the byte that carries
// stream_end). A zero-length entry, a length above TABLE_BITS or a code
// overrunning the stream end gives one error result and the rest of the
// stream is dropped. A data byte passes a check, then per result a read of
// the single table port, whose output is registered, and an evaluate and
// shift; a bare end marker, a check and a mark. No new item is taken until
// a byte is fully decoded; the output register lets the last result wait.
`default_nettype none

module huffman_table_decoder #(
  parameter int TABLE_BITS  = hfd_pkg::TABLE_BITS_DEF,
  parameter int SYMBOL_BITS = hfd_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [hfd_pkg::OP_W-1:0]     op,
  input  wire logic [hfd_pkg::INDEX_W-1:0]  table_index,
  input  wire logic [hfd_pkg::TSYM_W-1:0]   table_symbol,
  input  wire logic [hfd_pkg::LEN_W-1:0]    table_length,
  input  wire logic [hfd_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic [hfd_pkg::VBITS_W-1:0]  valid_bits,
  input  wire logic                         stream_end,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [hfd_pkg::SYM_W-1:0]    symbol,
  output logic                              has_symbol,
  output logic                              last_of_run,
  output logic                              stream_done,
  output logic                              error
);

  import hfd_pkg::*;

  localparam int ENTRY_W = SYMBOL_BITS + LEN_W;
  localparam int BUF_W   = TABLE_BITS + BYTE_W;
  localparam int CNT_W   = $clog2(BUF_W + 1);

  hfd_state_t state, state_next;

  logic [BUF_W-1:0] buffer, buffer_next;
  logic [CNT_W-1:0] count, count_next;
  logic             error_seen, error_seen_next;
  logic             end_flag, end_flag_next;

  logic             out_valid_next;
  logic [SYM_W-1:0] symbol_next;
  logic             has_symbol_next;
  logic             last_of_run_next;
  logic             stream_done_next;
  logic             error_next;

  logic                  accept;
  logic                  out_free;
  logic                  tbl_wr_en;
  logic                  tbl_rd_en;
  logic [ENTRY_W-1:0]    tbl_rd_data;
  logic [LEN_W-1:0]      ent_len;
  logic [SYMBOL_BITS-1:0] ent_sym;
  logic [CNT_W-1:0]      len_ext;
  logic                  ent_err;
  logic [BUF_W-1:0]      shifted;
  logic [CNT_W-1:0]      count_dec;
  logic                  more;
  logic [VBITS_W-1:0]    vb_clip;
  logic [BYTE_W:0]       vb_mask;
  logic [BYTE_W-1:0]     byte_bits;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign tbl_wr_en = accept && (op == OP_LOAD);
  assign tbl_rd_en = (state == ST_READ);

  hfd_table #(
    .TABLE_BITS (TABLE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (TABLE_BITS'(table_index)),
    .wr_data ({SYMBOL_BITS'(table_symbol), table_length}),
    .rd_en   (tbl_rd_en),
    .rd_addr (buffer[TABLE_BITS-1:0]),
    .rd_data (tbl_rd_data)
  );

  // append path
  assign vb_clip   = (valid_bits > VBITS_W'(BYTE_W)) ? VBITS_W'(BYTE_W) : valid_bits;
  assign vb_mask   = ((BYTE_W+1)'(1) << vb_clip) - (BYTE_W+1)'(1);
  assign byte_bits = data_byte & vb_mask[BYTE_W-1:0];

  // evaluate and shift path
  assign ent_len   = tbl_rd_data[LEN_W-1:0];
  assign ent_sym   = tbl_rd_data[ENTRY_W-1:LEN_W];
  assign len_ext   = CNT_W'(ent_len);
  assign ent_err   = (ent_len == '0) || (len_ext > CNT_W'(TABLE_BITS)) || (len_ext > count);
  assign shifted   = buffer >> ent_len;
  assign count_dec = count - len_ext;
  assign more      = !ent_err &&
                     ((count_dec >= CNT_W'(TABLE_BITS)) || (end_flag && (count_dec != '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      buffer     <= '0;
      count      <= '0;
      error_seen <= 1'b0;
      end_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      buffer     <= buffer_next;
      count      <= count_next;
      error_seen <= error_seen_next;
      end_flag   <= end_flag_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    symbol      <= symbol_next;
    has_symbol  <= has_symbol_next;
    last_of_run <= last_of_run_next;
    stream_done <= stream_done_next;
    error       <= error_next;
  end

  always_comb begin
    state_next       = state;
    buffer_next      = buffer;
    count_next       = count;
    error_seen_next  = error_seen;
    end_flag_next    = end_flag;
    out_valid_next   = out_valid && out_stall;
    symbol_next      = symbol;
    has_symbol_next  = has_symbol;
    last_of_run_next = last_of_run;
    stream_done_next = stream_done;
    error_next       = error;

    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_DATA)) begin
          end_flag_next = stream_end;
          if (!error_seen) begin
            buffer_next = buffer | (BUF_W'(byte_bits) << count);
            count_next  = count + CNT_W'(vb_clip);
          end
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((count >= CNT_W'(TABLE_BITS)) || (end_flag && (count != '0))) begin
          state_next = ST_READ;
        end else if (end_flag) begin
          state_next = ST_MARK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          symbol_next      = ent_err ? '0 : SYM_W'(ent_sym);
          has_symbol_next  = !ent_err;
          error_next       = ent_err;
          last_of_run_next = !more;
          stream_done_next = !more && end_flag;
          if (ent_err) begin
            buffer_next     = '0;
            count_next      = '0;
            error_seen_next = 1'b1;
          end else begin
            buffer_next = shifted;
            count_next  = count_dec;
          end
          if (more) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
            if (end_flag) begin
              buffer_next     = '0;
              count_next      = '0;
              error_seen_next = 1'b0;
            end
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          symbol_next      = '0;
          has_symbol_next  = 1'b0;
          error_next       = 1'b0;
          last_of_run_next = 1'b1;
          stream_done_next = 1'b1;
          buffer_next      = '0;
          count_next       = '0;
          error_seen_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[bench/huffman_table_decoder_tb.sv]
`timescale 1ns / 1ps

module huffman_table_decoder_tb;
  import hfd_pkg::*;

  localparam int TBITS = TABLE_BITS_DEF;
  localparam int TABLE_SIZE = 1 << TBITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_STRETCH = 400;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             has_symbol;
    logic             last_of_run;
    logic             stream_done;
    logic             error;
  } sym_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = OP_LOAD;
  logic [INDEX_W-1:0]  table_index = '0;
  logic [TSYM_W-1:0]   table_symbol = '0;
  logic [LEN_W-1:0]    table_length = '0;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic [VBITS_W-1:0]  valid_bits = '0;
  logic                stream_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SYM_W-1:0]    symbol;
  logic                has_symbol;
  logic                last_of_run;
  logic                stream_done;
  logic                error;

  // decoder state as predicted
  logic [TSYM_W-1:0]   table_sym [0:TABLE_SIZE-1];
  logic [LEN_W-1:0]    table_len [0:TABLE_SIZE-1];
  logic [TSYM_W-1:0]   plan_sym [0:TABLE_SIZE-1];
  logic [LEN_W-1:0]    plan_len [0:TABLE_SIZE-1];
  logic [23:0]         held_bits = '0;
  int                  held_count = 0;
  bit                  stream_failed = 1'b0;

  sym_result_t         pending_symbols[$];
  sym_result_t         got_result;
  sym_result_t         want_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int useful_items = 0;
  int loads_sent = 0;
  int bytes_sent = 0;
  int streams_closed = 0;
  int errors_flagged = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  huffman_table_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .table_index  (table_index),
    .table_symbol (table_symbol),
    .table_length (table_length),
    .data_byte    (data_byte),
    .valid_bits   (valid_bits),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .has_symbol   (has_symbol),
    .last_of_run  (last_of_run),
    .stream_done  (stream_done),
    .error        (error)
  );

  always #2 clk = ~clk;

  task automatic predict_symbols(input logic [BYTE_W-1:0] db, input logic [VBITS_W-1:0] vb,
                                 input logic fin);
    sym_result_t run_q[$];
    sym_result_t r;
    logic [23:0] chunk;
    logic [INDEX_W-1:0] peek;
    int nvb;
    int len;
    int last;
    nvb = (vb > 4'd8) ? 8 : int'(vb);
    if (!stream_failed) begin
      chunk = {16'd0, db} & ((24'd1 << nvb) - 24'd1);
      held_bits = held_bits | (chunk << held_count);
      held_count += nvb;
      while (held_count >= TBITS || (fin && held_count > 0)) begin
        peek = held_bits[TBITS-1:0];
        len = int'(table_len[peek]);
        r = '0;
        if (len == 0 || len > TBITS || len > held_count) begin
          r.error = 1'b1;
          run_q = {run_q, r};
          stream_failed = 1'b1;
          held_bits = '0;
          held_count = 0;
          errors_flagged++;
          break;
        end
        r.symbol = table_sym[peek];
        r.has_symbol = 1'b1;
        run_q = {run_q, r};
        held_bits = held_bits >> len;
        held_count -= len;
      end
    end
    if (fin) begin
      if (run_q.size() == 0) begin
        r = '0;
        run_q = {run_q, r};
      end
      last = run_q.size() - 1;
      r = run_q[last];
      r.stream_done = 1'b1;
      run_q[last] = r;
      held_bits = '0;
      held_count = 0;
      stream_failed = 1'b0;
      streams_closed++;
    end
    if (run_q.size() > 0) begin
      last = run_q.size() - 1;
      r = run_q[last];
      r.last_of_run = 1'b1;
      run_q[last] = r;
    end
    pending_symbols = {pending_symbols, run_q};
  endtask

  task automatic send_item(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] ti,
                           input logic [TSYM_W-1:0] ts, input logic [LEN_W-1:0] tl,
                           input logic [BYTE_W-1:0] db, input logic [VBITS_W-1:0] vb,
                           input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    op <= o;
    table_index <= ti;
    table_symbol <= ts;
    table_length <= tl;
    data_byte <= db;
    valid_bits <= vb;
    stream_end <= fin;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (o == OP_LOAD) begin
      table_sym[ti] = ts;
      table_len[ti] = tl;
      loads_sent++;
      useful_items++;
    end else begin
      if (!stream_failed || fin) useful_items++;
      bytes_sent++;
      predict_symbols(db, vb, fin);
    end
    @(negedge clk);
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [TSYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len);
    send_item(OP_LOAD, idx, sym, len, BYTE_W'($urandom), VBITS_W'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] db, input logic [VBITS_W-1:0] vb,
                           input logic fin);
    send_item(OP_DATA, INDEX_W'($urandom), TSYM_W'($urandom), LEN_W'($urandom), db, vb, fin);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    in_valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    @(negedge clk);
  endtask

  function automatic logic [INDEX_W-1:0] random_code_index();
    logic [INDEX_W-1:0] i;
    i = INDEX_W'($urandom);
    while (table_len[i] == 0 || table_len[i] > TBITS) i = INDEX_W'($urandom);
    return i;
  endfunction

  // encodes random symbols with the current table, optionally ending inside a code
  task automatic send_stream(input int count, input bit cut_short);
    bit bits[$];
    logic [INDEX_W-1:0] ci;
    logic [BYTE_W-1:0] b;
    logic [VBITS_W-1:0] vb;
    int i;
    int k;
    int nb;
    for (i = 0; i < count; i++) begin
      ci = random_code_index();
      for (k = 0; k < int'(table_len[ci]); k++) bits = {bits, ci[k]};
    end
    if (cut_short) begin
      ci = random_code_index();
      for (k = 0; k < int'(table_len[ci]) - 1; k++) bits = {bits, ci[k]};
    end
    while (bits.size() > 0) begin
      nb = (bits.size() < 8) ? bits.size() : 8;
      b = BYTE_W'($urandom);
      for (k = 0; k < nb; k++) b[k] = bits.pop_front();
      vb = VBITS_W'(nb);
      if (nb == 8 && $urandom_range(0, 9) == 0) vb = VBITS_W'($urandom_range(9, 15));
      if ($urandom_range(0, 19) == 0)
        send_load(INDEX_W'($urandom), TSYM_W'($urandom), LEN_W'($urandom_range(1, TBITS)));
      send_byte(b, vb, bits.size() == 0);
    end
  endtask

  // prefix-free table, lsb-first codes map to aligned blocks in bit-reversed index order
  task automatic test_table_load();
    int pos;
    int len;
    int span;
    int code_len;
    int k;
    int j;
    logic [TSYM_W-1:0] sym;
    logic [INDEX_W-1:0] fwd;
    logic [INDEX_W-1:0] slot;
    pos = 0;
    while (pos < TABLE_SIZE) begin
      len = (pos == 0) ? 1 : int'($urandom_range(1, TBITS));
      span = TABLE_SIZE >> len;
      while (pos % span != 0) begin
        len++;
        span = span >> 1;
      end
      sym = TSYM_W'($urandom);
      code_len = len;
      if (pos != 0 && $urandom_range(0, 99) < 6)
        code_len = $urandom_range(0, 1) ? 0 : int'($urandom_range(TBITS + 1, 15));
      for (k = pos; k < pos + span; k++) begin
        fwd = INDEX_W'(k);
        for (j = 0; j < TBITS; j++) slot[j] = fwd[TBITS-1-j];
        plan_sym[slot] = sym;
        plan_len[slot] = LEN_W'(code_len);
      end
      pos += span;
    end
    for (k = 0; k < TABLE_SIZE; k++) send_load(INDEX_W'(k), plan_sym[k], plan_len[k]);
  endtask

  task automatic test_special_cases();
    logic [TSYM_W-1:0] keep_sym [0:3];
    logic [LEN_W-1:0] keep_len [0:3];
    logic [INDEX_W-1:0] spots [0:3];
    int k;
    spots[0] = 12'h000;
    spots[1] = 12'hFFF;
    spots[2] = 12'h555;
    spots[3] = 12'h003;
    for (k = 0; k < 4; k++) begin
      keep_sym[k] = table_sym[spots[k]];
      keep_len[k] = table_len[spots[k]];
    end
    // one-bit zero code, most results per byte
    send_byte(8'h00, 4'd8, 1'b0);
    send_byte(8'h00, 4'd8, 1'b0);
    send_byte(8'h00, 4'd8, 1'b1);
    // longest code at the top index, bits above valid_bits ignored
    send_load(12'hFFF, 8'hA5, 4'd12);
    send_byte(8'hFF, 4'd8, 1'b0);
    send_byte(8'hFF, 4'd4, 1'b1);
    // valid_bits above 8
    send_byte(8'hFF, 4'd15, 1'b0);
    send_byte(8'hAF, 4'd4, 1'b1);
    // zero-length entry, rest of stream dropped
    send_load(12'h000, 8'h00, 4'd0);
    send_byte(8'h00, 4'd8, 1'b0);
    send_byte(8'h00, 4'd8, 1'b0);
    send_byte(8'h3C, 4'd8, 1'b0);
    send_byte(8'h00, 4'd0, 1'b1);
    // length above table bits
    send_load(12'h555, 8'h77, 4'd13);
    send_byte(8'h55, 4'd8, 1'b0);
    send_byte(8'h05, 4'd4, 1'b1);
    // code overruns the stream end
    send_load(12'h003, 8'h33, 4'd5);
    send_byte(8'h03, 4'd2, 1'b1);
    // empty stream gives a bare end marker
    send_byte(8'hFF, 4'd0, 1'b1);
    for (k = 0; k < 4; k++) send_load(spots[k], keep_sym[k], keep_len[k]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_cycles = HOLD_STRETCH;
    @(negedge clk);
    repeat (3) send_stream(8, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int start;
    int pick;
    start = useful_items;
    while (useful_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_stream($urandom_range(1, 24), 1'b0);
      end else if (pick < 78) begin
        send_stream($urandom_range(0, 12), 1'b1);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4))
          send_byte(BYTE_W'($urandom), VBITS_W'($urandom_range(0, 15)),
                    $urandom_range(0, 3) == 0);
      end else begin
        send_load(INDEX_W'($urandom), TSYM_W'($urandom), LEN_W'($urandom_range(0, 15)));
      end
    end
    wait_drained();
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result = {symbol, has_symbol, last_of_run, stream_done, error};
      if (pending_symbols.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: symbol=%02h has=%b last=%b done=%b err=%b",
                   got_result.symbol, got_result.has_symbol, got_result.last_of_run,
                   got_result.stream_done, got_result.error);
      end else begin
        want_result = pending_symbols.pop_front();
        results_checked++;
        if (got_result !== want_result) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected symbol=%02h has=%b last=%b done=%b err=%b",
                     results_checked, want_result.symbol, want_result.has_symbol,
                     want_result.last_of_run, want_result.stream_done, want_result.error);
            $display("  got symbol=%02h has=%b last=%b done=%b err=%b",
                     got_result.symbol, got_result.has_symbol, got_result.last_of_run,
                     got_result.stream_done, got_result.error);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idle(21, 82);
    test_table_load();
    test_special_cases();
    test_backpressure();
    test_random(145);
    set_idle(82, 21);
    test_random(145);
    set_idle(0, 0);
    test_random(140);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d table writes and %0d data bytes in %0d streams",
             loads_sent, bytes_sent, streams_closed);
    $display("%0d results checked, %0d decode errors predicted, %0d mismatches",
             results_checked, errors_flagged, mismatch_count);
    if (mismatch_count == 0 && pending_symbols.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
